// File: rtl/pfx_pkg.sv
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CH_W        = 8;
    localparam int ST_W        = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [ST_W-1:0] ST_OVER    = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CH_W-1:0] CH_DIV   = 8'h2F;

    typedef struct packed {
        logic            capture;
        logic            push;
        logic            read_nos;
        logic            pop_write;
        logic            use_div;
        logic            div_start;
        logic            set_err;
        logic [ST_W-1:0] err_code;
        logic            emit;
    } t_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic lt2;
        logic rhs_zero;
        logic last;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                        Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] ch, tlast last
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata[31:0] value, tuser[2:0] status
//
// One character at a time: DECODE, then FIN (+ - * put EXEC between, / EXEC and
// DIV, the one-bit-per-cycle restoring divider, which a zero divisor skips).
// The stack sits in a 32-entry memory with a registered read port.
// Reset (synchronous, active low) empties the stack and clears the error.
// A finished result waits in the output register; a last character stalls
// only while a previous result is still not taken.

module postfix_expression_evaluator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [7:0] ch
    input  logic                       i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [pfx_pkg::DATA_W-1:0] o_m_axis_tdata,  // [31:0] value
    output logic [pfx_pkg::ST_W-1:0]   o_m_axis_tuser   // [2:0] status
);
    import pfx_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfx_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_ch         (i_s_axis_tdata[CH_W-1:0]),
        .i_last       (i_s_axis_tlast),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_value  (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser)
    );

endmodule

// File: rtl/pfx_dp.sv
`timescale 1ns / 1ps

module pfx_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfx_pkg::t_cmd              i_cmd,
    output pfx_pkg::t_sts              o_sts,
    input  logic [pfx_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_last,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [pfx_pkg::DATA_W-1:0] o_out_value,
    output logic [pfx_pkg::ST_W-1:0]   o_out_status
);
    import pfx_pkg::*;

    logic [DATA_W-1:0]    r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]    r_tos;
    logic [DATA_W-1:0]    r_nos;
    logic [DEPTH_W-1:0]   r_depth;
    logic [ST_W-1:0]      r_err;
    logic [CH_W-1:0]      r_ch;
    logic                 r_last;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_value;
    logic [ST_W-1:0]      r_out_status;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dm;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [DEPTH_W-1:0] depth_m2;
    logic [IDX_W-1:0]   nos_idx;
    logic [IDX_W-1:0]   push_idx;
    logic [DATA_W-1:0]  digit_val;
    logic [DATA_W-1:0]  prod;
    logic [DATA_W-1:0]  alu_res;
    logic [DATA_W-1:0]  div_res;
    logic [DATA_W-1:0]  res;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [DATA_W-1:0]  mem_wd;
    logic [DATA_W:0]    rem_sh;
    logic [DATA_W:0]    diff;

    assign depth_m2  = r_depth - DEPTH_W'(2);
    assign nos_idx   = depth_m2[IDX_W-1:0];
    assign push_idx  = r_depth[IDX_W-1:0];
    assign digit_val = DATA_W'(r_ch - CH_ZERO);
    assign prod      = r_nos * r_tos;
    assign div_res   = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
    assign res       = i_cmd.use_div ? div_res : alu_res;

    always_comb begin
        case (r_ch)
            CH_PLUS:  alu_res = r_nos + r_tos;
            CH_MINUS: alu_res = r_nos - r_tos;
            CH_MUL:   alu_res = prod;
            default:  alu_res = '0;
        endcase
    end

    assign mem_we = i_cmd.push | i_cmd.pop_write;
    assign mem_wa = i_cmd.push ? push_idx : nos_idx;
    assign mem_wd = i_cmd.push ? digit_val : res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.read_nos) begin
            r_nos <= r_mem[nos_idx];
        end
    end

    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DIV_CNT_W'(DATA_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= r_nos[DATA_W-1] ? (DATA_W'(0) - r_nos) : r_nos;
            r_dm  <= r_tos[DATA_W-1] ? (DATA_W'(0) - r_tos) : r_tos;
            r_rem <= '0;
            r_neg <= r_nos[DATA_W-1] ^ r_tos[DATA_W-1];
        end else if (r_div_cnt != '0) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (i_cmd.push) begin
            r_tos <= digit_val;
        end else if (i_cmd.pop_write) begin
            r_tos <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= ST_OK;
        end else if (i_cmd.emit) begin
            r_depth <= '0;
            r_err   <= ST_OK;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.pop_write) begin
                r_depth <= r_depth - DEPTH_W'(1);
            end
            if (i_cmd.set_err && r_err == ST_OK) begin
                r_err <= i_cmd.err_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= (r_depth != '0) ? r_tos : '0;
            if (r_err != ST_OK) begin
                r_out_status <= r_err;
            end else if (r_depth == '0) begin
                r_out_status <= ST_EMPTY;
            end else begin
                r_out_status <= ST_OK;
            end
        end
    end

    always_comb begin
        o_sts.is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
        o_sts.is_op    = (r_ch == CH_PLUS) || (r_ch == CH_MINUS) ||
                         (r_ch == CH_MUL) || (r_ch == CH_DIV);
        o_sts.is_div   = (r_ch == CH_DIV);
        o_sts.full     = (r_depth == DEPTH_W'(STACK_DEPTH));
        o_sts.lt2      = (r_depth < DEPTH_W'(2));
        o_sts.rhs_zero = (r_tos == '0);
        o_sts.last     = r_last;
        o_sts.div_done = (r_div_cnt == '0);
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

endmodule

// File: rtl/pfx_ctrl.sv
`timescale 1ns / 1ps

module pfx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfx_pkg::t_sts i_sts,
    output pfx_pkg::t_cmd o_cmd
);
    import pfx_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                if (i_sts.is_digit) begin
                    if (i_sts.full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_OVER;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_sts.is_op) begin
                    if (i_sts.lt2) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_UNDER;
                    end else begin
                        o_cmd.read_nos = 1'b1;
                        n_state        = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (i_sts.is_div && !i_sts.rhs_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.pop_write = 1'b1;
                    if (i_sts.is_div) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_DIVZERO;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.pop_write = 1'b1;
                    o_cmd.use_div   = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pfx_chk.sv
`timescale 1ns / 1ps

module pfx_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic [7:0]                 i_s_axis_tdata,
    input logic                       i_s_axis_tlast,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [pfx_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic [pfx_pkg::ST_W-1:0]   o_m_axis_tuser
);
    import pfx_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY |-> o_m_axis_tdata == '0)
        else $error("empty result with nonzero value");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while previous one in progress");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind postfix_expression_evaluator_core pfx_chk u_pfx_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
